@@ src/xor_chain_packet_cipher_assert.svh @@
// xor_chain_packet_cipher_assert.svh: assertion macros for the packet cipher
// expects signals named clk and rst_n in the scope of every use
`ifndef XOR_CHAIN_PACKET_CIPHER_ASSERT_SVH
`define XOR_CHAIN_PACKET_CIPHER_ASSERT_SVH

// condition that holds at every edge out of reset
`define XCPC_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("xcpc invariant violated");

// condition that implies a consequence in the next cycle
`define XCPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("xcpc sequence violated");

`endif

@@ src/xcpc_pkg.sv @@
// xcpc_pkg: types, constants and key derivation for the packet cipher
// used by xcpc_core, xcpc_fifo and xor_chain_packet_cipher; no dependencies
package xcpc_pkg;

    // command codes
    localparam logic [1:0] CMD_ENC     = 2'd0;
    localparam logic [1:0] CMD_DEC     = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    // key schedule constants
    localparam logic [31:0] MIX_A      = 32'h9c30_d539;
    localparam logic [31:0] MIX_B      = 32'h930f_d7e2;
    localparam logic [31:0] MIX_C      = 32'h7c72_e993;
    localparam logic [31:0] STEP_ADD   = 32'h287e_ffc3;
    localparam logic [31:0] SEED_RESET = 32'd2147483647;

    // result queue geometry
    localparam int MAX_PUSH    = 4;
    localparam int PUSH_W      = 3;
    localparam int PUSH_IDX_W  = 2;
    localparam int FIFO_DEPTH  = 8;
    localparam int PTR_W       = 3;
    localparam int CNT_W       = PTR_W + 1;

    // one result word
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       err;
    } res_t;

    // up to four result words produced by one input word
    typedef struct packed {
        logic [PUSH_W-1:0]        count;
        res_t [MAX_PUSH-1:0]      r;
    } push_t;

    // low key word from seed: xor then rotate right by 13
    function automatic logic [31:0] rekey_low(input logic [31:0] seed);
        logic [31:0] w;
        w = seed ^ MIX_A;
        return {w[12:0], w[31:13]};
    endfunction

    // high key word from seed
    function automatic logic [31:0] rekey_high(input logic [31:0] seed);
        return MIX_B ^ rekey_low(seed) ^ MIX_C;
    endfunction

endpackage

@@ src/xor_chain_packet_cipher.sv @@
// xor_chain_packet_cipher: one input word a cycle, sustained while results drain as made.
// An accepted word waits in the input register until the queue has room, then its results
// go into the result queue. The fourth byte of a packet releases four results into an
// eight-entry queue, drained one a cycle while out_ready is high; the input register
// holds its word while more than four results are queued.
// Reset (rst_n, asynchronous): seed to 2147483647, key pairs rederived, idle, queue empty.
`include "xor_chain_packet_cipher_assert.svh"

module xor_chain_packet_cipher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [7:0]  data_in,
    input  logic        last_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  data_out,
    output logic        last_out,
    output logic        short_error
);

    logic [31:0]                 seed_reg;
    logic                        stage_valid_reg;
    logic [1:0]                  stage_cmd_reg;
    logic [7:0]                  stage_data_reg;
    logic                        stage_last_reg;
    logic                        advance;
    logic                        fifo_room;
    logic                        pop;
    logic [xcpc_pkg::CNT_W-1:0]  fifo_count;
    xcpc_pkg::push_t             core_push;
    xcpc_pkg::res_t              fifo_head;

    // seed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= xcpc_pkg::SEED_RESET;
        end
        else if (cfg_we)
        begin
            seed_reg <= cfg_data;
        end
    end

    // input register moves on when the queue can take a full head burst
    assign advance  = stage_valid_reg && fifo_room;
    assign in_ready = !stage_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stage_cmd_reg  <= cmd;
            stage_data_reg <= data_in;
            stage_last_reg <= last_in;
        end
    end

    // cipher datapath and key state
    xcpc_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (advance),
        .cmd     (stage_cmd_reg),
        .data_in (stage_data_reg),
        .last_in (stage_last_reg),
        .seed    (seed_reg),
        .push    (core_push)
    );

    // result queue
    assign pop = out_valid && out_ready;

    xcpc_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (core_push),
        .pop   (pop),
        .head  (fifo_head),
        .count (fifo_count),
        .room  (fifo_room)
    );

    assign out_valid   = fifo_count != '0;
    assign data_out    = fifo_head.data;
    assign last_out    = fifo_head.last;
    assign short_error = fifo_head.err;

    // checks
    `XCPC_ASSERT_ALWAYS(a_fifo_bound, fifo_count <= xcpc_pkg::CNT_W'(xcpc_pkg::FIFO_DEPTH))
    `XCPC_ASSERT_ALWAYS(a_err_word, !(out_valid && short_error) || (data_out == 8'd0 && last_out))
    `XCPC_ASSERT_NEXT(a_drain, pop && fifo_count == xcpc_pkg::CNT_W'(1) && core_push.count == '0, !out_valid)

endmodule

@@ src/xcpc_core.sv @@
// xcpc_core: key pairs, packet state and the per-word cipher datapath
// depends on xcpc_pkg
module xcpc_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  logic [1:0]         cmd,
    input  logic [7:0]         data_in,
    input  logic               last_in,
    input  logic [31:0]        seed,
    output xcpc_pkg::push_t    push
);

    logic [31:0] send_low_reg, send_low_next;
    logic [31:0] send_high_reg, send_high_next;
    logic [31:0] recv_low_reg, recv_low_next;
    logic [31:0] recv_high_reg, recv_high_next;
    logic [7:0]  head_reg [4];
    logic [7:0]  head_next [4];
    logic [7:0]  chain_reg, chain_next;
    logic [2:0]  pos_reg, pos_next;
    logic        past_reg, past_next;
    logic        dir_reg, dir_next;

    logic        dir_cur;
    logic [63:0] key64;
    logic [7:0]  k [8];
    logic [7:0]  h3;
    logic [7:0]  e0, e1, e2, e3;
    logic [7:0]  er [4];
    logic [7:0]  d0, d1, d2, d3;
    logic [7:0]  dr [4];
    logic [7:0]  tail_r;
    logic [31:0] mask;
    logic        upd;

    // direction is latched by the first word of a packet
    assign dir_cur = (!past_reg && pos_reg == 3'd0) ? cmd[0] : dir_reg;
    assign key64   = dir_cur ? {recv_high_reg, recv_low_reg}
                             : {send_high_reg, send_low_reg};

    // key bytes, little-endian over low then high word
    always_comb
    begin
        for (int j = 0; j < 8; j++)
        begin
            k[j] = key64[8*j +: 8];
        end
    end

    assign h3 = data_in;

    // head encrypt: forward chain then backward fix-up
    always_comb
    begin
        e0    = head_reg[0] ^ k[0];
        e1    = head_reg[1] ^ e0 ^ k[1];
        e2    = head_reg[2] ^ e1 ^ k[2];
        e3    = h3 ^ e2 ^ k[3];
        er[3] = e3 ^ k[2];
        er[2] = e2 ^ er[3] ^ k[3];
        er[1] = e1 ^ er[2] ^ k[4];
        er[0] = e0 ^ er[1] ^ k[5];
    end

    // head decrypt: undo the fix-up then the chain
    always_comb
    begin
        d0    = head_reg[0] ^ head_reg[1] ^ k[5];
        d1    = head_reg[1] ^ head_reg[2] ^ k[4];
        d2    = head_reg[2] ^ h3 ^ k[3];
        d3    = h3 ^ k[2];
        dr[0] = d0 ^ k[0];
        dr[1] = d1 ^ k[1] ^ d0;
        dr[2] = d2 ^ k[2] ^ d1;
        dr[3] = d3 ^ k[3] ^ d2;
    end

    // words past the head chain with the previous ciphertext byte; the first one chains with e3
    assign tail_r = data_in ^ chain_reg ^ k[pos_reg];

    // next state and result words
    always_comb
    begin
        send_low_next  = send_low_reg;
        send_high_next = send_high_reg;
        recv_low_next  = recv_low_reg;
        recv_high_next = recv_high_reg;
        head_next      = head_reg;
        chain_next     = chain_reg;
        pos_next       = pos_reg;
        past_next      = past_reg;
        dir_next       = dir_reg;
        push           = '0;
        upd            = 1'b0;
        mask           = '0;
        if (go)
        begin
            unique case (cmd)
                xcpc_pkg::CMD_RESTART:
                begin
                    send_low_next  = xcpc_pkg::rekey_low(seed);
                    recv_low_next  = xcpc_pkg::rekey_low(seed);
                    send_high_next = xcpc_pkg::rekey_high(seed);
                    recv_high_next = xcpc_pkg::rekey_high(seed);
                    chain_next     = '0;
                    pos_next       = '0;
                    past_next      = 1'b0;
                end
                xcpc_pkg::CMD_ENC, xcpc_pkg::CMD_DEC:
                begin
                    dir_next = dir_cur;
                    if (!past_reg)
                    begin
                        head_next[pos_reg[1:0]] = data_in;
                        if (pos_reg[1:0] != 2'd3)
                        begin
                            if (last_in)
                            begin
                                // short packet: one error word, keys untouched
                                push.count     = xcpc_pkg::PUSH_W'(1);
                                push.r[0].data = '0;
                                push.r[0].last = 1'b1;
                                push.r[0].err  = 1'b1;
                                chain_next     = '0;
                                pos_next       = '0;
                                past_next      = 1'b0;
                            end
                            else
                            begin
                                pos_next = pos_reg + 3'd1;
                            end
                        end
                        else
                        begin
                            push.count = xcpc_pkg::PUSH_W'(xcpc_pkg::MAX_PUSH);
                            for (int i = 0; i < 4; i++)
                            begin
                                push.r[i].data = dir_cur ? dr[i] : er[i];
                                push.r[i].last = (i == 3) ? last_in : 1'b0;
                                push.r[i].err  = 1'b0;
                            end
                            if (dir_cur)
                            begin
                                head_next = dr;
                            end
                            chain_next = dir_cur ? d3 : e3;
                            past_next  = 1'b1;
                            pos_next   = 3'd4;
                            upd        = last_in;
                        end
                    end
                    else
                    begin
                        push.count     = xcpc_pkg::PUSH_W'(1);
                        push.r[0].data = tail_r;
                        push.r[0].last = last_in;
                        push.r[0].err  = 1'b0;
                        chain_next     = dir_cur ? data_in : tail_r;
                        pos_next       = pos_reg + 3'd1;
                        upd            = last_in;
                    end
                    // packet end: fold the plaintext head into the used pair
                    if (upd)
                    begin
                        mask = {head_next[3], head_next[2], head_next[1], head_next[0]};
                        if (dir_cur)
                        begin
                            recv_low_next  = recv_low_reg ^ mask;
                            recv_high_next = recv_high_reg + xcpc_pkg::STEP_ADD;
                        end
                        else
                        begin
                            send_low_next  = send_low_reg ^ mask;
                            send_high_next = send_high_reg + xcpc_pkg::STEP_ADD;
                        end
                        chain_next = '0;
                        pos_next   = '0;
                        past_next  = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // key and packet state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            send_low_reg  <= xcpc_pkg::rekey_low(xcpc_pkg::SEED_RESET);
            recv_low_reg  <= xcpc_pkg::rekey_low(xcpc_pkg::SEED_RESET);
            send_high_reg <= xcpc_pkg::rekey_high(xcpc_pkg::SEED_RESET);
            recv_high_reg <= xcpc_pkg::rekey_high(xcpc_pkg::SEED_RESET);
            chain_reg     <= '0;
            pos_reg       <= '0;
            past_reg      <= 1'b0;
            dir_reg       <= 1'b0;
        end
        else
        begin
            send_low_reg  <= send_low_next;
            recv_low_reg  <= recv_low_next;
            send_high_reg <= send_high_next;
            recv_high_reg <= recv_high_next;
            chain_reg     <= chain_next;
            pos_reg       <= pos_next;
            past_reg      <= past_next;
            dir_reg       <= dir_next;
        end
    end

    // head buffer, no reset
    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
    end

endmodule

@@ src/xcpc_fifo.sv @@
// xcpc_fifo: result queue taking up to four words a cycle, giving one
// depends on xcpc_pkg
module xcpc_fifo (
    input  logic                        clk,
    input  logic                        rst_n,
    input  xcpc_pkg::push_t             push,
    input  logic                        pop,
    output xcpc_pkg::res_t              head,
    output logic [xcpc_pkg::CNT_W-1:0]  count,
    output logic                        room
);

    xcpc_pkg::res_t                 mem_reg [xcpc_pkg::FIFO_DEPTH];
    logic [xcpc_pkg::PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [xcpc_pkg::PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [xcpc_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [xcpc_pkg::FIFO_DEPTH-1:0] wr_en;
    logic [xcpc_pkg::PUSH_IDX_W-1:0] wr_idx [xcpc_pkg::FIFO_DEPTH];

    // which entries take which incoming word
    always_comb
    begin
        logic [xcpc_pkg::PTR_W-1:0] off;
        off = '0;
        for (int i = 0; i < xcpc_pkg::FIFO_DEPTH; i++)
        begin
            off       = xcpc_pkg::PTR_W'(i) - wr_ptr_reg;
            wr_idx[i] = off[xcpc_pkg::PUSH_IDX_W-1:0];
            wr_en[i]  = xcpc_pkg::CNT_W'(off) < xcpc_pkg::CNT_W'(push.count);
        end
    end

    // pointer and fill arithmetic
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + xcpc_pkg::PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + xcpc_pkg::PTR_W'(pop);
        count_next  = count_reg + xcpc_pkg::CNT_W'(push.count) - xcpc_pkg::CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < xcpc_pkg::FIFO_DEPTH; i++)
        begin
            if (wr_en[i])
            begin
                mem_reg[i] <= push.r[wr_idx[i]];
            end
        end
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign count = count_reg;
    assign room  = count_reg <= xcpc_pkg::CNT_W'(xcpc_pkg::FIFO_DEPTH - xcpc_pkg::MAX_PUSH);

endmodule

@@ verif/xor_chain_packet_cipher_check.sv @@
// xor_chain_packet_cipher_check: watches the word channels of the packet cipher,
// predicts every result byte from its own copy of the key state and compares
// depends on xcpc_pkg for the command codes, key constants and the result word type
module xor_chain_packet_cipher_check
    import xcpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [7:0]  data_in,
    input  logic        last_in,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  data_out,
    input  logic        last_out,
    input  logic        short_error,
    output int          failures,
    output int          outstanding
);

    // predicted cipher state
    logic [31:0]     seed_reg;
    logic [31:0]     tx_lo;
    logic [31:0]     tx_hi;
    logic [31:0]     rx_lo;
    logic [31:0]     rx_hi;
    logic [3:0][7:0] head;
    logic [7:0]      chain;
    logic [2:0]      pos;
    logic            in_body;
    logic            dir;

    // result bytes still to come, oldest first
    res_t cipher_bytes_due[$];

    initial
    begin
        failures    = 0;
        outstanding = 0;
    end

    // both key pairs from the current seed: xor, rotate right by 13
    task automatic rekey_pairs();
        logic [31:0] w;
        w     = seed_reg ^ MIX_A;
        w     = (w >> 13) | (w << 19);
        tx_lo = w;
        rx_lo = w;
        tx_hi = MIX_B ^ w ^ MIX_C;
        rx_hi = tx_hi;
    endtask

    task automatic go_idle();
        chain   = 8'h00;
        pos     = 3'd0;
        in_body = 1'b0;
    endtask

    task automatic queue_byte(input logic [7:0] d, input logic l, input logic e);
        res_t r;
        r.data = d;
        r.last = l;
        r.err  = e;
        cipher_bytes_due.push_back(r);
        outstanding++;
    endtask

    // one accepted input word: update the state and queue the bytes it releases
    task automatic cipher_word(input logic [1:0] c, input logic [7:0] d, input logic l);
        logic [7:0][7:0] kb;
        logic [3:0][7:0] fix;
        logic [7:0]      e0;
        logic [7:0]      e1;
        logic [7:0]      e2;
        logic [7:0]      e3;
        logic [7:0]      r;
        if (c == CMD_RESTART)
        begin
            rekey_pairs();
            go_idle();
            return;
        end
        if (c != CMD_ENC && c != CMD_DEC)
            return;

        // direction is latched by the first byte of a packet
        if (!in_body && pos == 3'd0)
            dir = (c == CMD_DEC);
        kb = dir ? {rx_hi, rx_lo} : {tx_hi, tx_lo};

        if (!in_body)
        begin
            head[pos[1:0]] = d;
            if (pos[1:0] != 2'd3)
            begin
                // packet too short: one error byte, keys untouched
                if (l)
                begin
                    queue_byte(8'h00, 1'b1, 1'b1);
                    go_idle();
                    return;
                end
                pos = pos + 3'd1;
                return;
            end
            if (!dir)
            begin
                // forward chain then backward fix-up
                e0     = head[0] ^ kb[0];
                e1     = head[1] ^ e0 ^ kb[1];
                e2     = head[2] ^ e1 ^ kb[2];
                e3     = head[3] ^ e2 ^ kb[3];
                fix[3] = e3 ^ kb[2];
                fix[2] = e2 ^ fix[3] ^ kb[3];
                fix[1] = e1 ^ fix[2] ^ kb[4];
                fix[0] = e0 ^ fix[1] ^ kb[5];
            end
            else
            begin
                // undo the fix-up, then the forward chain
                e0     = head[0] ^ head[1] ^ kb[5];
                e1     = head[1] ^ head[2] ^ kb[4];
                e2     = head[2] ^ head[3] ^ kb[3];
                e3     = head[3] ^ kb[2];
                fix[0] = e0 ^ kb[0];
                fix[1] = e1 ^ kb[1] ^ e0;
                fix[2] = e2 ^ kb[2] ^ e1;
                fix[3] = e3 ^ kb[3] ^ e2;
                head   = fix;
            end
            chain = e3;
            queue_byte(fix[0], 1'b0, 1'b0);
            queue_byte(fix[1], 1'b0, 1'b0);
            queue_byte(fix[2], 1'b0, 1'b0);
            queue_byte(fix[3], l, 1'b0);
            in_body = 1'b1;
            pos     = 3'd4;
        end
        else
        begin
            // body byte, key index wraps modulo 8
            r     = d ^ chain ^ kb[pos];
            chain = dir ? d : r;
            queue_byte(r, l, 1'b0);
            pos   = pos + 3'd1;
        end

        // packet end moves the pair that was used
        if (l)
        begin
            if (dir)
            begin
                rx_lo = rx_lo ^ head;
                rx_hi = rx_hi + STEP_ADD;
            end
            else
            begin
                tx_lo = tx_lo ^ head;
                tx_hi = tx_hi + STEP_ADD;
            end
            go_idle();
        end
    endtask

    // compare results first, then predict from the word taken at the same edge
    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            seed_reg = SEED_RESET;
            rekey_pairs();
            go_idle();
            dir  = 1'b0;
            head = '0;
            cipher_bytes_due.delete();
            outstanding = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (cipher_bytes_due.size() == 0)
                begin
                    if (failures < 10)
                        $display("unexpected result word: data %h last %b err %b",
                                 data_out, last_out, short_error);
                    failures++;
                end
                else
                begin
                    want = cipher_bytes_due.pop_front();
                    outstanding--;
                    if (want.data !== data_out || want.last !== last_out ||
                        want.err !== short_error)
                    begin
                        if (failures < 10)
                            $display("result mismatch: expected data %h last %b err %b,",
                                     want.data, want.last, want.err,
                                     " got data %h last %b err %b",
                                     data_out, last_out, short_error);
                        failures++;
                    end
                end
            end
            if (in_valid && in_ready)
                cipher_word(cmd, data_in, last_in);
            if (cfg_we)
                seed_reg = cfg_data;
        end
    end

endmodule

@@ verif/xor_chain_packet_cipher_test.sv @@
// xor_chain_packet_cipher_test: drives directed and random packets into the cipher
// with random gaps and stalls, and gives the verdict from the checker's count
// depends on xcpc_pkg, xor_chain_packet_cipher and xor_chain_packet_cipher_check
module xor_chain_packet_cipher_test;
    import xcpc_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 2000;
    localparam int PHASES     = 6;
    localparam int PHASE_WORDS = 30;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [31:0] cfg_data  = '0;
    logic        in_valid  = 1'b0;
    logic [1:0]  cmd       = CMD_ENC;
    logic [7:0]  data_in   = '0;
    logic        last_in   = 1'b0;
    logic        out_ready = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic [7:0]  data_out;
    logic        last_out;
    logic        short_error;
    int          failures;
    int          outstanding;

    // idling controls, changed per phase
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    int words_sent = 0;
    int stall_left = 0;
    int idle_cycles = 0;

    xor_chain_packet_cipher i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .data_in     (data_in),
        .last_in     (last_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .data_out    (data_out),
        .last_out    (last_out),
        .short_error (short_error)
    );

    xor_chain_packet_cipher_check i_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .data_in     (data_in),
        .last_in     (last_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .data_out    (data_out),
        .last_out    (last_out),
        .short_error (short_error),
        .failures    (failures),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1, 2);
        if (roll < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 40);
    endfunction

    // receiver stalls
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else if (!rx_steady && $urandom_range(0, 3) == 0)
        begin
            out_ready <= 1'b0;
            stall_left = pick_gap() - 1;
        end
        else
            out_ready <= 1'b1;
    end

    // watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // one input word, after an optional gap, held until taken
    task automatic send_word(input logic [1:0] c, input logic [7:0] d, input logic l);
        int gap;
        gap = (tx_steady || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        data_in  <= d;
        last_in  <= l;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        if (c != CMD_UNUSED)
            words_sent++;
    endtask

    // random packet; with mix set, later bytes carry either direction code
    task automatic send_packet(input int len, input logic [1:0] first, input bit mix);
        logic [1:0] c;
        for (int i = 0; i < len; i++)
        begin
            c = first;
            if (i > 0 && mix)
                c = $urandom_range(0, 1) ? CMD_DEC : CMD_ENC;
            if ($urandom_range(0, 29) == 0)
                send_word(CMD_UNUSED, 8'($urandom), 1'($urandom));
            send_word(c, 8'($urandom), i == len - 1);
        end
    endtask

    // stop sending until every expected byte is out and the pipe is empty
    task automatic settle();
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_seed(input logic [31:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    initial
    begin
        int roll;
        int target;
        logic [1:0] dir_cmd;
        logic [31:0] new_seed;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // full packets at byte extremes, reset seed
        send_word(CMD_ENC, 8'h00, 1'b0);
        send_word(CMD_ENC, 8'hff, 1'b0);
        send_word(CMD_ENC, 8'h00, 1'b0);
        send_word(CMD_ENC, 8'hff, 1'b1);
        send_word(CMD_DEC, 8'hff, 1'b0);
        send_word(CMD_DEC, 8'h00, 1'b0);
        send_word(CMD_DEC, 8'haa, 1'b0);
        send_word(CMD_DEC, 8'h55, 1'b0);
        send_word(CMD_DEC, 8'hff, 1'b1);
        // short packets of one, two and three bytes
        send_word(CMD_ENC, 8'h5a, 1'b1);
        send_word(CMD_DEC, 8'h00, 1'b0);
        send_word(CMD_DEC, 8'hff, 1'b1);
        send_word(CMD_ENC, 8'h01, 1'b0);
        send_word(CMD_ENC, 8'h80, 1'b0);
        send_word(CMD_ENC, 8'h7f, 1'b1);
        // unused command is ignored
        send_word(CMD_UNUSED, 8'hff, 1'b1);
        // direction stays with the first byte
        send_word(CMD_ENC, 8'ha5, 1'b0);
        send_word(CMD_DEC, 8'h3c, 1'b0);
        send_word(CMD_DEC, 8'hc3, 1'b0);
        send_word(CMD_ENC, 8'h0f, 1'b1);
        // restart drops a packet in progress
        send_word(CMD_ENC, 8'h11, 1'b0);
        send_word(CMD_ENC, 8'h22, 1'b0);
        send_word(CMD_RESTART, 8'h00, 1'b0);

        // random phases, each under its own seed
        for (int phase = 0; phase < PHASES; phase++)
        begin
            tx_steady = (phase == 1);
            rx_steady = (phase == 1 || phase == 4);
            settle();
            case (phase)
                0:       new_seed = 32'h0000_0000;
                1:       new_seed = 32'hffff_ffff;
                2:       new_seed = SEED_RESET;
                default: new_seed = $urandom;
            endcase
            write_seed(new_seed);
            send_word(CMD_RESTART, 8'($urandom), 1'($urandom));
            target = words_sent + PHASE_WORDS;
            while (words_sent < target)
            begin
                roll    = $urandom_range(0, 99);
                dir_cmd = $urandom_range(0, 1) ? CMD_DEC : CMD_ENC;
                if (roll < 68)
                    send_packet($urandom_range(4, 12), dir_cmd, $urandom_range(0, 4) == 0);
                else if (roll < 78)
                    send_packet($urandom_range(13, 30), dir_cmd, 1'b0);
                else if (roll < 88)
                    send_packet($urandom_range(1, 3), dir_cmd, 1'b0);
                else if (roll < 94)
                begin
                    // packet cut short by a restart
                    for (int i = $urandom_range(1, 6); i > 0; i--)
                        send_word(dir_cmd, 8'($urandom), 1'b0);
                    send_word(CMD_RESTART, 8'($urandom), 1'($urandom));
                end
                else if (roll < 97)
                    send_word(CMD_UNUSED, 8'($urandom), 1'($urandom));
                else
                    settle();
            end
        end

        settle();
        if (failures == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/xcpc_pkg.sv
src/xcpc_core.sv
src/xcpc_fifo.sv
src/xor_chain_packet_cipher.sv
verif/xor_chain_packet_cipher_check.sv
verif/xor_chain_packet_cipher_test.sv
